>>> design/cssq_pkg.sv
// Shared types, codes and constants of the clock source switch sequencer.
`timescale 1ns / 1ps

package cssq_pkg;

   localparam int TICK_BITS_DEFAULT = 24;
   localparam int NOW_BITS          = 24;
   localparam int TIMEOUT_BITS      = 23;
   localparam int LIMIT_BITS        = 16;
   localparam int CFG_DATA_BITS     = 23;
   localparam int CSR_INDEX_BITS    = 1;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_TIMEOUT = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LIMIT   = 1'b1;

   localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RESET = 23'd1000;
   localparam logic [LIMIT_BITS-1:0]   LIMIT_RESET   = 16'd1000;

   localparam logic [7:0] OSC_BIT        = 8'h40;
   localparam logic [7:0] TICKSPD_BITS   = 8'h38;
   localparam logic [7:0] CLKSPD_BITS    = 8'h07;
   localparam logic [7:0] TICKSPD_CLAMP  = 8'h08;
   localparam logic [7:0] RC_DIVIDER     = 8'h01;
   localparam logic [2:0] SLEEP_REQUIRED = 3'd4;

   localparam logic OP_BEGIN = 1'b0;
   localparam logic OP_POLL  = 1'b1;

   localparam logic [1:0] PHASE_IDLE     = 2'd0;
   localparam logic [1:0] PHASE_REQUEST  = 2'd1;
   localparam logic [1:0] PHASE_ROLLBACK = 2'd2;

   localparam logic [2:0] RES_OK          = 3'd0;
   localparam logic [2:0] RES_TIMEBASE    = 3'd1;
   localparam logic [2:0] RES_CHANGED     = 3'd2;
   localparam logic [2:0] RES_RANGE       = 3'd3;
   localparam logic [2:0] RES_TIMEOUT     = 3'd4;
   localparam logic [2:0] RES_POLL_LIMIT  = 3'd5;
   localparam logic [2:0] RES_UNSUPPORTED = 3'd6;

   localparam logic [2:0] RB_NONE        = 3'd0;
   localparam logic [2:0] RB_UNCONFIRMED = 3'd7;

   typedef struct packed {
      logic                operation;
      logic                clock_source;
      logic                interrupts_enabled_any;
      logic [2:0]          sleep_mode_bits;
      logic [7:0]          command_sample;
      logic [7:0]          status_sample;
      logic [NOW_BITS-1:0] now_ticks;
      logic                deadline_fault;
      logic                expiry_fault;
   } cssq_req_type;

   typedef struct packed {
      logic                  write_valid;
      logic [7:0]            write_command;
      logic                  done_res;
      logic [2:0]            result_code;
      logic [2:0]            rollback_code;
      logic [1:0]            phase_now;
      logic [LIMIT_BITS-1:0] poll_count;
      logic [NOW_BITS-1:0]   elapsed;
      logic [7:0]            saved_value;
      logic [7:0]            requested_value;
   } cssq_rsp_type;

   typedef struct packed {
      logic [TIMEOUT_BITS-1:0] timeout_len;
      logic [LIMIT_BITS-1:0]   max_polls;
   } cssq_cfg_type;

   // The RC oscillator with a zero tick speed field reports the clamped tick speed.
   function automatic logic [7:0] status_for_cmd(input logic [7:0] cmd);
      if (((cmd & OSC_BIT) != 8'h00) && ((cmd & TICKSPD_BITS) == 8'h00)) begin
         return cmd | TICKSPD_CLAMP;
      end
      return cmd;
   endfunction

endpackage

>>> design/cssq_req_if.sv
// Request channel interface of the clock source switch sequencer.
`timescale 1ns / 1ps

interface cssq_req_if
   import cssq_pkg::*;
();
   logic         valid;
   logic         ready;
   cssq_req_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

>>> design/cssq_rsp_if.sv
// Response channel interface of the clock source switch sequencer.
`timescale 1ns / 1ps

interface cssq_rsp_if
   import cssq_pkg::*;
();
   logic         valid;
   logic         ready;
   cssq_rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

>>> design/cssq_csr.sv
// Configuration registers of the clock source switch sequencer.
`timescale 1ns / 1ps

module cssq_csr
   import cssq_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CFG_DATA_BITS-1:0]  csr_write_data,
   output cssq_cfg_type              cfg
);

   logic [TIMEOUT_BITS-1:0] timeout_ff;
   logic [TIMEOUT_BITS-1:0] timeout_in;
   logic [LIMIT_BITS-1:0]   limit_ff;
   logic [LIMIT_BITS-1:0]   limit_in;

   always_comb begin
      timeout_in = timeout_ff;
      limit_in   = limit_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_TIMEOUT: timeout_in = csr_write_data[TIMEOUT_BITS-1:0];
            CSR_LIMIT:   limit_in   = csr_write_data[LIMIT_BITS-1:0];
            default: begin
               timeout_in = timeout_ff;
               limit_in   = limit_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
         limit_ff   <= LIMIT_RESET;
      end else begin
         timeout_ff <= timeout_in;
         limit_ff   <= limit_in;
      end
   end

   assign cfg.timeout_len = timeout_ff;
   assign cfg.max_polls   = limit_ff;

endmodule

>>> design/cssq_core.sv
// Sequencer state and the single-pass step logic for one request.
`timescale 1ns / 1ps

module cssq_core
   import cssq_pkg::*;
#(
   parameter int TICK_BITS = TICK_BITS_DEFAULT
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         go,
   input  cssq_req_type item,
   input  cssq_cfg_type cfg,
   output cssq_rsp_type result
);

   localparam int WIDE_BITS = (TICK_BITS > TIMEOUT_BITS) ? TICK_BITS : TIMEOUT_BITS;
   localparam logic [TICK_BITS-1:0] HALF_M1 = {1'b0, {(TICK_BITS-1){1'b1}}};

   logic [1:0]            phase_ff, phase_in;
   logic [7:0]            saved_cmd_ff, saved_cmd_in;
   logic [7:0]            requested_cmd_ff, requested_cmd_in;
   logic [TICK_BITS-1:0]  start_tick_ff, start_tick_in;
   logic [TICK_BITS-1:0]  previous_tick_ff, previous_tick_in;
   logic [TICK_BITS-1:0]  deadline_tick_ff, deadline_tick_in;
   logic                  deadline_bad_ff, deadline_bad_in;
   logic [LIMIT_BITS-1:0] polls_taken_ff, polls_taken_in;
   logic                  osc_seen_ff, osc_seen_in;
   logic [2:0]            request_result_ff, request_result_in;
   logic [TICK_BITS-1:0]  elapsed_count_ff, elapsed_count_in;

   logic [WIDE_BITS-1:0]  timeout_wide;
   logic [TICK_BITS-1:0]  eff_timeout;
   logic [LIMIT_BITS-1:0] eff_limit;
   logic [TICK_BITS-1:0]  now_t;
   logic [TICK_BITS-1:0]  deadline_new;
   logic [7:0]            begin_request;
   logic                  begin_bad;
   logic [7:0]            poll_target;
   logic                  poll_seen;
   logic [LIMIT_BITS-1:0] polls_inc;
   logic [TICK_BITS-1:0]  elapsed_new;
   logic [TICK_BITS-1:0]  since_prev;
   logic [TICK_BITS-1:0]  past_deadline;
   logic                  expired;
   logic                  poll_done;
   logic [2:0]            poll_code;
   logic                  poll_prev_upd;
   logic [TICK_BITS-1:0]  rep_elapsed;

   assign timeout_wide = WIDE_BITS'(cfg.timeout_len);
   assign eff_timeout  = ((timeout_wide >> (TICK_BITS - 1)) != '0) ? HALF_M1
                                                                : timeout_wide[TICK_BITS-1:0];
   assign eff_limit    = (cfg.max_polls == '0) ? LIMIT_BITS'(1) : cfg.max_polls;

   assign now_t         = TICK_BITS'(item.now_ticks);
   assign deadline_new  = now_t + eff_timeout;
   assign begin_request = (item.command_sample & ~(OSC_BIT | CLKSPD_BITS)) |
                          (item.clock_source ? (OSC_BIT | RC_DIVIDER) : 8'h00);
   assign begin_bad = item.interrupts_enabled_any ||
                      (item.sleep_mode_bits != SLEEP_REQUIRED) ||
                      ((item.command_sample & CLKSPD_BITS) !=
                       (item.command_sample[6] ? RC_DIVIDER : 8'h00)) ||
                      (item.status_sample != status_for_cmd(item.command_sample));

   assign poll_target   = (phase_ff == PHASE_ROLLBACK) ? saved_cmd_ff : requested_cmd_ff;
   assign poll_seen     = osc_seen_ff ||
                          (((item.status_sample ^ requested_cmd_ff) & OSC_BIT) == 8'h00);
   assign polls_inc     = polls_taken_ff + LIMIT_BITS'(1);
   assign elapsed_new   = now_t - start_tick_ff;
   assign since_prev    = now_t - previous_tick_ff;
   assign past_deadline = now_t - deadline_tick_ff;
   assign expired       = !past_deadline[TICK_BITS-1];

   // Checks of one poll in priority order; poll_done low means keep waiting.
   always_comb begin
      poll_done     = 1'b1;
      poll_code     = RES_OK;
      poll_prev_upd = 1'b0;
      if (deadline_bad_ff) begin
         poll_code = RES_TIMEBASE;
      end else if (item.command_sample != poll_target) begin
         poll_code = RES_CHANGED;
      end else if (item.expiry_fault) begin
         poll_code = RES_TIMEBASE;
      end else if (elapsed_new[TICK_BITS-1] || since_prev[TICK_BITS-1]) begin
         poll_code = RES_RANGE;
      end else if (expired && (elapsed_new > eff_timeout)) begin
         poll_code = RES_TIMEOUT;
      end else if (poll_seen && (item.status_sample == status_for_cmd(poll_target))) begin
         poll_code = RES_OK;
      end else if (expired) begin
         poll_code = RES_TIMEOUT;
      end else begin
         poll_prev_upd = 1'b1;
         if (polls_inc >= eff_limit) begin
            poll_code = RES_POLL_LIMIT;
         end else begin
            poll_done = 1'b0;
         end
      end
   end

   always_comb begin
      phase_in          = phase_ff;
      saved_cmd_in      = saved_cmd_ff;
      requested_cmd_in  = requested_cmd_ff;
      start_tick_in     = start_tick_ff;
      previous_tick_in  = previous_tick_ff;
      deadline_tick_in  = deadline_tick_ff;
      deadline_bad_in   = deadline_bad_ff;
      polls_taken_in    = polls_taken_ff;
      osc_seen_in       = osc_seen_ff;
      request_result_in = request_result_ff;
      elapsed_count_in  = elapsed_count_ff;
      result            = '0;
      result.poll_count = polls_taken_ff;
      rep_elapsed       = elapsed_count_ff;

      if ((item.operation == OP_BEGIN) && (phase_ff == PHASE_IDLE)) begin
         polls_taken_in    = '0;
         elapsed_count_in  = '0;
         saved_cmd_in      = item.command_sample;
         requested_cmd_in  = begin_request;
         result.poll_count = '0;
         rep_elapsed       = '0;
         if (begin_bad) begin
            result.done_res    = 1'b1;
            result.result_code = RES_UNSUPPORTED;
         end else if (item.command_sample == begin_request) begin
            result.done_res    = 1'b1;
            result.result_code = RES_OK;
         end else begin
            osc_seen_in          = 1'b0;
            phase_in             = PHASE_REQUEST;
            start_tick_in        = now_t;
            previous_tick_in     = now_t;
            deadline_tick_in     = deadline_new;
            deadline_bad_in      = item.deadline_fault;
            result.write_valid   = 1'b1;
            result.write_command = begin_request;
         end
      end else if ((item.operation == OP_POLL) && (phase_ff != PHASE_IDLE)) begin
         osc_seen_in = poll_seen;
         if (!deadline_bad_ff) begin
            polls_taken_in    = polls_inc;
            elapsed_count_in  = elapsed_new;
            result.poll_count = polls_inc;
            rep_elapsed       = elapsed_new;
         end
         if (poll_prev_upd) begin
            previous_tick_in = now_t;
         end
         if (poll_done) begin
            if (phase_ff == PHASE_REQUEST) begin
               if (poll_code == RES_OK) begin
                  phase_in           = PHASE_IDLE;
                  result.done_res    = 1'b1;
                  result.result_code = RES_OK;
               end else begin
                  request_result_in    = poll_code;
                  phase_in             = PHASE_ROLLBACK;
                  start_tick_in        = now_t;
                  previous_tick_in     = now_t;
                  deadline_tick_in     = deadline_new;
                  deadline_bad_in      = item.deadline_fault;
                  polls_taken_in       = '0;
                  elapsed_count_in     = '0;
                  result.write_valid   = 1'b1;
                  result.write_command = saved_cmd_ff;
               end
            end else begin
               phase_in           = PHASE_IDLE;
               result.done_res    = 1'b1;
               result.result_code = request_result_ff;
               if (!poll_seen && ((poll_code == RES_TIMEOUT) ||
                                  (poll_code == RES_POLL_LIMIT))) begin
                  result.rollback_code = RB_UNCONFIRMED;
               end else begin
                  result.rollback_code = poll_code + 3'd1;
               end
            end
         end
      end

      result.phase_now       = phase_in;
      result.elapsed         = NOW_BITS'(rep_elapsed);
      result.saved_value     = saved_cmd_in;
      result.requested_value = requested_cmd_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PHASE_IDLE;
         saved_cmd_ff      <= '0;
         requested_cmd_ff  <= '0;
         start_tick_ff     <= '0;
         previous_tick_ff  <= '0;
         deadline_tick_ff  <= '0;
         deadline_bad_ff   <= 1'b0;
         polls_taken_ff    <= '0;
         osc_seen_ff       <= 1'b0;
         request_result_ff <= RES_OK;
         elapsed_count_ff  <= '0;
      end else if (go) begin
         phase_ff          <= phase_in;
         saved_cmd_ff      <= saved_cmd_in;
         requested_cmd_ff  <= requested_cmd_in;
         start_tick_ff     <= start_tick_in;
         previous_tick_ff  <= previous_tick_in;
         deadline_tick_ff  <= deadline_tick_in;
         deadline_bad_ff   <= deadline_bad_in;
         polls_taken_ff    <= polls_taken_in;
         osc_seen_ff       <= osc_seen_in;
         request_result_ff <= request_result_in;
         elapsed_count_ff  <= elapsed_count_in;
      end
   end

endmodule

>>> design/clock_source_switch_sequencer_top.sv
// Top level of the clock source switch sequencer.
`timescale 1ns / 1ps

// The sequencer takes one request per clock cycle when not held off by back-pressure and
// returns exactly one response per request: the request lands in an input register,
// the state update and response are computed in one pass and captured in the
// response register. Throughput is one request per cycle, limited only by how fast
// the response register is drained; a held response still lets one more request
// into the input register. Configuration writes take effect on the next cycle and
// are expected only while no request is in flight.

module clock_source_switch_sequencer_top
   import cssq_pkg::*;
#(
   parameter int TICK_BITS = TICK_BITS_DEFAULT
)
(
   input  logic                      clock,
   input  logic                      reset,
   cssq_req_if.sink                  req_ch,
   cssq_rsp_if.source                rsp_ch,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CFG_DATA_BITS-1:0]  csr_write_data
);

   logic         in_valid_ff, in_valid_in;
   cssq_req_type in_data_ff;
   logic         out_valid_ff, out_valid_in;
   cssq_rsp_type out_data_ff;
   cssq_rsp_type step_result;
   cssq_cfg_type cfg;
   logic         advance;
   logic         req_take;

   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign req_take     = req_ch.valid && req_ch.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_ch.data;
      end
      if (advance) begin
         out_data_ff <= step_result;
      end
   end

   cssq_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   cssq_core #(
      .TICK_BITS (TICK_BITS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .go     (advance),
      .item   (in_data_ff),
      .cfg    (cfg),
      .result (step_result)
   );

   assign rsp_ch.valid = out_valid_ff;
   assign rsp_ch.data  = out_data_ff;

endmodule

>>> design/cssq_checker.sv
// Port-level checks of the clock source switch sequencer and their binding.
`timescale 1ns / 1ps

module cssq_checker
   import cssq_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input cssq_rsp_type rsp_data
);

   a_no_write_no_command: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.write_valid) |-> (rsp_data.write_command == 8'h00))
      else $error("Response carries a command without a write.");

   a_codes_only_when_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.done_res) |->
         ((rsp_data.result_code == RES_OK) && (rsp_data.rollback_code == RB_NONE)))
      else $error("Result codes are set on an unfinished response.");

   a_done_returns_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.done_res) |->
         ((rsp_data.phase_now == PHASE_IDLE) && !rsp_data.write_valid))
      else $error("Finished response is not idle or still writes.");

   a_write_starts_wait: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.write_valid) |->
         ((rsp_data.phase_now == PHASE_REQUEST) || (rsp_data.phase_now == PHASE_ROLLBACK)))
      else $error("Command write without a wait phase.");

   a_stalled_response_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("Stalled response changed.");

endmodule

bind clock_source_switch_sequencer_top cssq_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_data  (rsp_ch.data)
);

>>> bench/testbench.sv
// Self-checking testbench of the clock source switch sequencer.
`timescale 1ns / 1ps

module testbench;
   import cssq_pkg::*;

   localparam logic [NOW_BITS-1:0] HALF_RANGE = NOW_BITS'(1) << (NOW_BITS - 1);

   class switch_tracker;
      logic [TIMEOUT_BITS-1:0] timeout_len = TIMEOUT_RESET;
      logic [LIMIT_BITS-1:0]   max_polls = LIMIT_RESET;
      logic [1:0]              phase = PHASE_IDLE;
      logic [7:0]              saved_cmd = '0;
      logic [7:0]              requested_cmd = '0;
      logic [NOW_BITS-1:0]     start_tick = '0;
      logic [NOW_BITS-1:0]     previous_tick = '0;
      logic [NOW_BITS-1:0]     deadline_tick = '0;
      logic [NOW_BITS-1:0]     elapsed_count = '0;
      logic                    deadline_bad = 1'b0;
      logic                    osc_seen = 1'b0;
      logic [LIMIT_BITS-1:0]   polls_taken = '0;
      logic [2:0]              request_result = RES_OK;
      cssq_rsp_type            pending_responses[$];
      int                      failures = 0;

      function logic [7:0] rc_status(logic [7:0] cmd);
         if ((cmd & OSC_BIT) != 8'h00 && (cmd & TICKSPD_BITS) == 8'h00) begin
            return cmd | TICKSPD_CLAMP;
         end
         return cmd;
      endfunction

      function logic [NOW_BITS-1:0] timeout_window();
         logic [NOW_BITS-1:0] ticks;
         ticks = NOW_BITS'(timeout_len);
         return (ticks >= HALF_RANGE) ? HALF_RANGE - 1'b1 : ticks;
      endfunction

      function logic [LIMIT_BITS-1:0] limit_window();
         return (max_polls == '0) ? LIMIT_BITS'(1) : max_polls;
      endfunction

      function void set_register(logic [CSR_INDEX_BITS-1:0] index,
                                 logic [CFG_DATA_BITS-1:0] value);
         if (index == CSR_TIMEOUT) begin
            timeout_len = value[TIMEOUT_BITS-1:0];
         end else begin
            max_polls = value[LIMIT_BITS-1:0];
         end
      endfunction

      function bit ignores(cssq_req_type r);
         if (r.operation == OP_BEGIN) begin
            return phase != PHASE_IDLE;
         end
         return phase == PHASE_IDLE;
      endfunction

      function void start_wait(logic [1:0] next_phase, logic [NOW_BITS-1:0] now, logic fault);
         phase = next_phase;
         start_tick = now;
         previous_tick = now;
         deadline_tick = now + timeout_window();
         deadline_bad = fault;
         polls_taken = '0;
         elapsed_count = '0;
      endfunction

      function bit poll_phase(input logic [7:0] cmd, input logic [7:0] status,
                              input logic [NOW_BITS-1:0] now, input logic expiry_fault,
                              output logic [2:0] code);
         logic [7:0]          target;
         logic [NOW_BITS-1:0] past_deadline;
         logic [NOW_BITS-1:0] since_previous;
         logic                expired;
         target = (phase == PHASE_ROLLBACK) ? saved_cmd : requested_cmd;
         code = RES_OK;
         if (((status ^ requested_cmd) & OSC_BIT) == 8'h00) begin
            osc_seen = 1'b1;
         end
         if (deadline_bad) begin
            code = RES_TIMEBASE;
            return 1'b1;
         end
         polls_taken = polls_taken + 1'b1;
         elapsed_count = now - start_tick;
         if (cmd != target) begin
            code = RES_CHANGED;
            return 1'b1;
         end
         if (expiry_fault) begin
            code = RES_TIMEBASE;
            return 1'b1;
         end
         past_deadline = now - deadline_tick;
         since_previous = now - previous_tick;
         expired = past_deadline < HALF_RANGE;
         if (elapsed_count >= HALF_RANGE || since_previous >= HALF_RANGE) begin
            code = RES_RANGE;
            return 1'b1;
         end
         if (expired && elapsed_count > timeout_window()) begin
            code = RES_TIMEOUT;
            return 1'b1;
         end
         if (osc_seen && status == rc_status(target)) begin
            code = RES_OK;
            return 1'b1;
         end
         if (expired) begin
            code = RES_TIMEOUT;
            return 1'b1;
         end
         previous_tick = now;
         if (polls_taken >= limit_window()) begin
            code = RES_POLL_LIMIT;
            return 1'b1;
         end
         return 1'b0;
      endfunction

      function void note_request(cssq_req_type r);
         cssq_rsp_type e;
         logic [2:0]   code;
         logic [7:0]   divider;
         logic         bad_state;
         bit           finished;
         e = '0;
         if (r.operation == OP_BEGIN && phase == PHASE_IDLE) begin
            polls_taken = '0;
            elapsed_count = '0;
            saved_cmd = r.command_sample;
            requested_cmd = (r.command_sample & ~(OSC_BIT | CLKSPD_BITS)) |
                            (r.clock_source ? (OSC_BIT | RC_DIVIDER) : 8'h00);
            divider = ((r.command_sample & OSC_BIT) != 8'h00) ? RC_DIVIDER : 8'h00;
            bad_state = r.interrupts_enabled_any || r.sleep_mode_bits != SLEEP_REQUIRED ||
                        (r.command_sample & CLKSPD_BITS) != divider ||
                        r.status_sample != rc_status(r.command_sample);
            if (bad_state) begin
               e.done_res = 1'b1;
               e.result_code = RES_UNSUPPORTED;
            end else if (saved_cmd == requested_cmd) begin
               e.done_res = 1'b1;
               e.result_code = RES_OK;
            end else begin
               osc_seen = 1'b0;
               start_wait(PHASE_REQUEST, r.now_ticks, r.deadline_fault);
               e.write_valid = 1'b1;
               e.write_command = requested_cmd;
            end
         end else if (r.operation == OP_POLL && phase != PHASE_IDLE) begin
            finished = poll_phase(r.command_sample, r.status_sample, r.now_ticks,
                                  r.expiry_fault, code);
            e.poll_count = polls_taken;
            e.elapsed = elapsed_count;
            if (finished && phase == PHASE_REQUEST) begin
               if (code == RES_OK) begin
                  phase = PHASE_IDLE;
                  e.done_res = 1'b1;
                  e.result_code = RES_OK;
               end else begin
                  request_result = code;
                  start_wait(PHASE_ROLLBACK, r.now_ticks, r.deadline_fault);
                  e.write_valid = 1'b1;
                  e.write_command = saved_cmd;
               end
            end else if (finished) begin
               if (!osc_seen && (code == RES_TIMEOUT || code == RES_POLL_LIMIT)) begin
                  e.rollback_code = RB_UNCONFIRMED;
               end else begin
                  e.rollback_code = code + 3'd1;
               end
               phase = PHASE_IDLE;
               e.done_res = 1'b1;
               e.result_code = request_result;
            end
         end else begin
            e.poll_count = polls_taken;
            e.elapsed = elapsed_count;
         end
         e.phase_now = phase;
         e.saved_value = saved_cmd;
         e.requested_value = requested_cmd;
         pending_responses.push_back(e);
      endfunction

      task report(string what);
         failures++;
         $display("Mismatch at %0t ns: %s", $time, what);
      endtask

      task compare(string name, logic [31:0] got, logic [31:0] want);
         if (got !== want) begin
            report($sformatf("%s expected %0h, got %0h", name, want, got));
         end
      endtask

      task check_response(cssq_rsp_type got);
         cssq_rsp_type want;
         if (pending_responses.size() == 0) begin
            report("response arrived with no request outstanding");
            return;
         end
         want = pending_responses.pop_front();
         compare("write_valid", got.write_valid, want.write_valid);
         compare("write_command", got.write_command, want.write_command);
         compare("done_res", got.done_res, want.done_res);
         compare("result_code", got.result_code, want.result_code);
         compare("rollback_code", got.rollback_code, want.rollback_code);
         compare("phase_now", got.phase_now, want.phase_now);
         compare("poll_count", got.poll_count, want.poll_count);
         compare("elapsed", got.elapsed, want.elapsed);
         compare("saved_value", got.saved_value, want.saved_value);
         compare("requested_value", got.requested_value, want.requested_value);
      endtask
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_write_enable;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CFG_DATA_BITS-1:0]  csr_write_data;

   cssq_req_if req_bus();
   cssq_rsp_if rsp_bus();

   switch_tracker       tracker = new();
   logic [NOW_BITS-1:0] tick_now = '0;
   int                  live_items = 0;
   int                  calm_items = 0;
   bit                  steady_tail = 1'b0;
   bit                  long_hold_due = 1'b0;

   clock_source_switch_sequencer_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_bus.sink),
      .rsp_ch           (rsp_bus.source),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         tracker.check_response(rsp_bus.data);
      end
   end

   // The response side stalls in short bursts, runs free for stretches, and holds off
   // once for a long time so that the block fills up and pushes back on requests.
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (steady_tail) begin
            rsp_bus.ready <= 1'b1;
         end else if (long_hold_due) begin
            long_hold_due = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (400) @(negedge clock);
            rsp_bus.ready <= 1'b1;
         end else if ($urandom_range(0, 29) == 0) begin
            rsp_bus.ready <= 1'b1;
            repeat ($urandom_range(20, 80)) @(negedge clock);
         end else if ($urandom_range(0, 5) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(0, 12)) @(negedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin
      #20_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   function automatic cssq_req_type random_item();
      logic [63:0] raw;
      raw = {$urandom(), $urandom()};
      return raw[$bits(cssq_req_type)-1:0];
   endfunction

   function automatic cssq_req_type begin_item(logic [7:0] cmd, logic [7:0] status,
                                               logic source, logic irq_on,
                                               logic [2:0] sleep_bits,
                                               logic [NOW_BITS-1:0] now, logic dfault);
      cssq_req_type r;
      r = random_item();
      r.operation = OP_BEGIN;
      r.clock_source = source;
      r.interrupts_enabled_any = irq_on;
      r.sleep_mode_bits = sleep_bits;
      r.command_sample = cmd;
      r.status_sample = status;
      r.now_ticks = now;
      r.deadline_fault = dfault;
      return r;
   endfunction

   function automatic cssq_req_type poll_item(logic [7:0] cmd, logic [7:0] status,
                                              logic [NOW_BITS-1:0] now, logic efault,
                                              logic dfault);
      cssq_req_type r;
      r = random_item();
      r.operation = OP_POLL;
      r.command_sample = cmd;
      r.status_sample = status;
      r.now_ticks = now;
      r.expiry_fault = efault;
      r.deadline_fault = dfault;
      return r;
   endfunction

   function automatic logic [7:0] supported_command();
      logic [7:0] cmd;
      cmd = 8'($urandom_range(0, 255)) & ~(OSC_BIT | CLKSPD_BITS);
      if ($urandom_range(0, 3) == 0) begin
         cmd = cmd & ~TICKSPD_BITS;
      end
      if ($urandom_range(0, 1) == 1) begin
         cmd = cmd | OSC_BIT | RC_DIVIDER;
      end
      return cmd;
   endfunction

   task automatic send_request(cssq_req_type r);
      int gap;
      if (calm_items > 0) begin
         calm_items--;
      end else if (!steady_tail && $urandom_range(0, 40) == 0) begin
         calm_items = $urandom_range(20, 60);
      end else if (!steady_tail && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 13);
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      if (!tracker.ignores(r)) begin
         live_items++;
      end
      @(negedge clock);
      req_bus.valid <= 1'b1;
      req_bus.data <= r;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      tracker.note_request(r);
   endtask

   task automatic drain();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (tracker.pending_responses.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_INDEX_BITS-1:0] index,
                                 logic [CFG_DATA_BITS-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      tracker.set_register(index, value);
   endtask

   // One switch attempt: a supported begin followed by polls until the block is idle again.
   task automatic run_switch();
      logic [7:0]          cmd;
      logic [7:0]          target;
      logic [7:0]          status;
      logic [NOW_BITS-1:0] wait_window;
      logic [NOW_BITS-1:0] advance;
      logic                source;
      int                  polls;
      int                  pick;
      cmd = supported_command();
      source = ((cmd & OSC_BIT) != 8'h00);
      if ($urandom_range(0, 9) != 0) begin
         source = !source;
      end
      if ($urandom_range(0, 9) == 0) begin
         tick_now = NOW_BITS'($urandom());
      end else begin
         tick_now = tick_now + NOW_BITS'($urandom_range(0, 5000));
      end
      send_request(begin_item(cmd, tracker.rc_status(cmd), source, 1'b0, SLEEP_REQUIRED,
                              tick_now, $urandom_range(0, 24) == 0));
      polls = 0;
      while (tracker.phase != PHASE_IDLE) begin
         if ($urandom_range(0, 29) == 0) begin
            send_request(random_item());
         end
         target = (tracker.phase == PHASE_ROLLBACK) ? tracker.saved_cmd : tracker.requested_cmd;
         wait_window = tracker.timeout_window();
         pick = $urandom_range(0, 99);
         if (polls > 40) begin
            advance = wait_window + 1'b1;
         end else if (pick < 3) begin
            advance = HALF_RANGE + NOW_BITS'($urandom_range(0, HALF_RANGE - 1));
         end else if (pick < 8) begin
            advance = wait_window + NOW_BITS'($urandom_range(0, 40));
         end else begin
            advance = NOW_BITS'($urandom_range(0, wait_window / 8 + 2));
         end
         tick_now = tick_now + advance;
         pick = $urandom_range(0, 99);
         if (pick < 20) begin
            status = tracker.rc_status(target);
         end else if (pick < 55) begin
            status = (8'($urandom_range(0, 255)) & ~OSC_BIT) | (tracker.requested_cmd & OSC_BIT);
         end else begin
            status = 8'($urandom_range(0, 255));
         end
         if ($urandom_range(0, 49) == 0) begin
            target = 8'($urandom_range(0, 255));
         end
         send_request(poll_item(target, status, tick_now, $urandom_range(0, 49) == 0,
                                $urandom_range(0, 24) == 0));
         polls++;
      end
   endtask

   initial begin
      int timeout_set[6];
      int limit_set[6];
      int goal;
      req_bus.valid = 1'b0;
      req_bus.data = '0;
      csr_write_enable = 1'b0;
      csr_index = CSR_TIMEOUT;
      csr_write_data = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_register(CSR_TIMEOUT, CFG_DATA_BITS'(100));
      write_register(CSR_LIMIT, CFG_DATA_BITS'(3));

      // Unsupported states, a switch that is already in place, and busy or idle items.
      send_request(poll_item(8'h00, 8'h00, 24'h000000, 1'b0, 1'b0));
      send_request(begin_item(8'h00, 8'h00, 1'b1, 1'b1, SLEEP_REQUIRED, 24'd0, 1'b0));
      send_request(begin_item(8'h00, 8'h00, 1'b1, 1'b0, 3'd3, 24'd0, 1'b0));
      send_request(begin_item(8'h40, 8'h48, 1'b1, 1'b0, SLEEP_REQUIRED, 24'd0, 1'b0));
      send_request(begin_item(8'h00, 8'h01, 1'b1, 1'b0, SLEEP_REQUIRED, 24'd0, 1'b0));
      send_request(begin_item(8'h41, 8'h49, 1'b1, 1'b0, SLEEP_REQUIRED, 24'd0, 1'b0));
      send_request(begin_item(8'h00, 8'h00, 1'b1, 1'b0, SLEEP_REQUIRED, 24'hFFFFF0, 1'b0));
      send_request(begin_item(8'h00, 8'h00, 1'b0, 1'b0, SLEEP_REQUIRED, 24'd0, 1'b0));
      send_request(poll_item(8'h41, 8'h49, 24'h000010, 1'b0, 1'b0));

      // Command changed, then a rollback that runs into the poll limit without evidence.
      send_request(begin_item(8'hC9, 8'hC9, 1'b0, 1'b0, SLEEP_REQUIRED, 24'd1000, 1'b0));
      send_request(poll_item(8'h12, 8'h40, 24'd1005, 1'b0, 1'b0));
      send_request(poll_item(8'hC9, 8'hFF, 24'd1015, 1'b0, 1'b0));
      send_request(poll_item(8'hC9, 8'h7F, 24'd1025, 1'b0, 1'b0));
      send_request(poll_item(8'hC9, 8'hC9, 24'd1035, 1'b0, 1'b0));

      // Deadline fault, then a rollback confirmed after the source was seen.
      send_request(begin_item(8'h00, 8'h00, 1'b1, 1'b0, SLEEP_REQUIRED, 24'h7FFFFF, 1'b1));
      send_request(poll_item(8'h41, 8'h00, 24'h800005, 1'b0, 1'b0));
      send_request(poll_item(8'h00, 8'h40, 24'h800010, 1'b0, 1'b0));
      send_request(poll_item(8'h00, 8'h00, 24'h800020, 1'b0, 1'b0));

      // Expiry fault, then a forward jump of half the range.
      send_request(begin_item(8'h00, 8'h00, 1'b1, 1'b0, SLEEP_REQUIRED, 24'd500, 1'b0));
      send_request(poll_item(8'h41, 8'h41, 24'd510, 1'b1, 1'b0));
      send_request(poll_item(8'h00, 8'h00, 24'd510 + HALF_RANGE, 1'b0, 1'b0));

      // Timeout, then a rollback whose clock runs backward.
      send_request(begin_item(8'h00, 8'h00, 1'b1, 1'b0, SLEEP_REQUIRED, 24'd0, 1'b0));
      send_request(poll_item(8'h41, 8'h49, 24'd200, 1'b0, 1'b0));
      send_request(poll_item(8'h00, 8'h00, 24'd100, 1'b0, 1'b0));

      timeout_set = '{1000, 0, 8388607, $urandom_range(10, 300), $urandom_range(0, 2000), 300};
      limit_set = '{1000, 1, 65535, $urandom_range(1, 6), 0, 1000};
      tick_now = NOW_BITS'($urandom());
      for (int p = 0; p < 6; p++) begin
         drain();
         write_register(CSR_TIMEOUT, CFG_DATA_BITS'(timeout_set[p]));
         write_register(CSR_LIMIT, CFG_DATA_BITS'(limit_set[p]));
         if (p == 0) begin
            long_hold_due = 1'b1;
         end
         if (p == 5) begin
            steady_tail = 1'b1;
         end
         goal = live_items + 250;
         while (live_items < goal) begin
            if ($urandom_range(0, 6) == 0) begin
               send_request(random_item());
            end else begin
               run_switch();
            end
         end
      end

      drain();
      repeat (8) @(posedge clock);
      if (tracker.failures == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
